>>> design/ignition_coil_dwell_control_assert.svh
// Assertion macros shared by the checkers of the ignition coil dwell control block.
// Needs a clock named clk and an active-high reset named rst in the scope of use.
`ifndef IGNITION_COIL_DWELL_CONTROL_ASSERT_SVH
`define IGNITION_COIL_DWELL_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/icdc_pkg.sv
// Package of the ignition coil dwell control block: field widths, codes,
// reset values and the stage hand-off type. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package icdc_pkg;

  // Field widths.
  localparam int ANGLE_W    = 16;
  localparam int DPU_W      = 24;
  localparam int RPM_W      = 15;
  localparam int TIME_W     = 32;
  localparam int DWELL_W    = 16;
  localparam int TIDX_W     = 6;
  localparam int STATE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Fixed-point layout.
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int DPU_FRAC_BITS   = 24;
  localparam int NEED_W          = DPU_W + DWELL_W;
  localparam int AVAIL_SH        = DPU_FRAC_BITS - ANGLE_FRAC_BITS;

  // Advance table geometry.
  localparam int TABLE_DEPTH_DEF = 40;
  localparam int RPM_STEP        = 100;

  // Exact reciprocal for rpm / RPM_STEP over every RPM_W-bit rpm value.
  localparam int RECIP_SH = RPM_W + $clog2(RPM_STEP);
  localparam int RECIP_W  = RPM_W + 2;
  localparam int RECIP    = ((1 << RECIP_SH) + RPM_STEP - 1) / RPM_STEP;
  localparam int RPM_PROD_W = RPM_W + RECIP_W;

  // Commands carried by an input item.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_TABLE  = 1'b1;

  // Coil state codes on the result.
  localparam logic [STATE_W-1:0] STATE_PRIMED     = 2'd0;
  localparam logic [STATE_W-1:0] STATE_CHARGING   = 2'd1;
  localparam logic [STATE_W-1:0] STATE_DISCHARGED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DWELL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DWELL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd2;

  // Configuration reset values.
  localparam logic [DWELL_W-1:0] MIN_DWELL_RST = 16'd2000;
  localparam logic [DWELL_W-1:0] MAX_DWELL_RST = 16'd4000;
  localparam logic [RPM_W-1:0]   MIN_SPEED_RST = 15'd300;

  // One item as it leaves the front stage.
  typedef struct packed {
    logic                 valid;
    logic                 is_write;
    logic                 rolled;
    logic [ANGLE_W-1:0]   angle;
    logic [RPM_W-1:0]     rpm;
    logic [TIME_W-1:0]    timestamp;
    logic [NEED_W-1:0]    need;
  } icdc_stage_t;

endpackage

`default_nettype wire

>>> design/ignition_coil_dwell_control.sv
// Ignition coil dwell control takes one item per clock cycle while results are
// taken; a stalled result holds the input back. The accepting edge registers
// the item in the stage register and issues the registered read of the advance
// table memory; when the result register is empty or being emptied, the coil
// decision is registered there. The result register lets the next item in while a
// result waits to be taken. The table is not cleared after reset and must be
// loaded with table items before engine updates read it; configuration
// registers are taken at any time and should be written while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module ignition_coil_dwell_control #(
  parameter int TABLE_DEPTH = icdc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [icdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [icdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic                            cycle_wrap,
  input  wire logic [icdc_pkg::ANGLE_W-1:0]    angle,
  input  wire logic [icdc_pkg::DPU_W-1:0]      deg_per_us,
  input  wire logic [icdc_pkg::RPM_W-1:0]      rpm,
  input  wire logic [icdc_pkg::TIME_W-1:0]     timestamp_us,
  input  wire logic [icdc_pkg::TIDX_W-1:0]     table_index,
  input  wire logic [icdc_pkg::ANGLE_W-1:0]    table_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [icdc_pkg::STATE_W-1:0]    coil_state,
  output logic                                 coil_drive,
  output logic      [icdc_pkg::RPM_W-1:0]      charge_start_rpm,
  output logic      [icdc_pkg::ANGLE_W-1:0]    fire_angle
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [icdc_pkg::DWELL_W-1:0] min_dwell_us;
  logic [icdc_pkg::DWELL_W-1:0] max_dwell_us;
  logic [icdc_pkg::RPM_W-1:0]   min_speed_rpm;

  logic                         accept;
  logic                         advance;
  icdc_pkg::icdc_stage_t        stage;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr;
  logic                         wr_en;
  logic [ADDR_W-1:0]            wr_addr;
  logic [icdc_pkg::ANGLE_W-1:0] wr_data;
  logic [icdc_pkg::ANGLE_W-1:0] rd_data;

  // Configuration registers; the write channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_dwell_us  <= icdc_pkg::MIN_DWELL_RST;
      max_dwell_us  <= icdc_pkg::MAX_DWELL_RST;
      min_speed_rpm <= icdc_pkg::MIN_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icdc_pkg::CFG_MIN_DWELL: min_dwell_us  <= cfg_data;
        icdc_pkg::CFG_MAX_DWELL: max_dwell_us  <= cfg_data;
        icdc_pkg::CFG_MIN_SPEED: min_speed_rpm <= cfg_data[icdc_pkg::RPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: a new item enters when the stage is empty or moving on.
  assign in_ready = !stage.valid || advance;
  assign accept   = in_valid && in_ready;

  icdc_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .advance      (advance),
    .command      (command),
    .cycle_wrap   (cycle_wrap),
    .angle        (angle),
    .deg_per_us   (deg_per_us),
    .rpm          (rpm),
    .timestamp_us (timestamp_us),
    .table_index  (table_index),
    .table_value  (table_value),
    .min_dwell_us (min_dwell_us),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .stage        (stage)
  );

  icdc_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  icdc_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .stage            (stage),
    .table_data       (rd_data),
    .max_dwell_us     (max_dwell_us),
    .min_speed_rpm    (min_speed_rpm),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .coil_state       (coil_state),
    .coil_drive       (coil_drive),
    .charge_start_rpm (charge_start_rpm),
    .fire_angle       (fire_angle)
  );

endmodule

`default_nettype wire

>>> design/icdc_table.sv
// Advance table memory: one write port and one read port with registered data.
// Depends on icdc_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module icdc_table #(
  parameter int TABLE_DEPTH = icdc_pkg::TABLE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [ADDR_W-1:0]            wr_addr,
  input  wire logic [icdc_pkg::ANGLE_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [ADDR_W-1:0]            rd_addr,
  output logic      [icdc_pkg::ANGLE_W-1:0] rd_data
);

  logic [icdc_pkg::ANGLE_W-1:0] mem [TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/icdc_front.sv
// Front stage: table slot from rpm, table read and write requests, and the
// registered item with its minimum-dwell angle product. Depends on icdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icdc_front #(
  parameter int TABLE_DEPTH = icdc_pkg::TABLE_DEPTH_DEF,
  localparam int ADDR_W = $clog2(TABLE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          advance,
  input  wire logic                          command,
  input  wire logic                          cycle_wrap,
  input  wire logic [icdc_pkg::ANGLE_W-1:0]  angle,
  input  wire logic [icdc_pkg::DPU_W-1:0]    deg_per_us,
  input  wire logic [icdc_pkg::RPM_W-1:0]    rpm,
  input  wire logic [icdc_pkg::TIME_W-1:0]   timestamp_us,
  input  wire logic [icdc_pkg::TIDX_W-1:0]   table_index,
  input  wire logic [icdc_pkg::ANGLE_W-1:0]  table_value,
  input  wire logic [icdc_pkg::DWELL_W-1:0]  min_dwell_us,
  output logic                               rd_en,
  output logic      [ADDR_W-1:0]             rd_addr,
  output logic                               wr_en,
  output logic      [ADDR_W-1:0]             wr_addr,
  output logic      [icdc_pkg::ANGLE_W-1:0]  wr_data,
  output icdc_pkg::icdc_stage_t              stage
);

  localparam int IDX_CMP_W = 9;
  localparam logic [icdc_pkg::RPM_W-1:0] LAST_SLOT = icdc_pkg::RPM_W'(TABLE_DEPTH - 1);

  logic [icdc_pkg::RPM_PROD_W-1:0] rpm_prod;
  logic [icdc_pkg::RPM_W-1:0]      rpm_quo;
  logic [icdc_pkg::RPM_W-1:0]      slot;

  // Table slot: rpm / RPM_STEP by reciprocal multiply, minus one, clamped.
  always_comb begin
    rpm_prod = icdc_pkg::RPM_PROD_W'(rpm) * icdc_pkg::RPM_PROD_W'(icdc_pkg::RECIP);
    rpm_quo  = icdc_pkg::RPM_W'(rpm_prod >> icdc_pkg::RECIP_SH);
    if (rpm_quo == '0) begin
      slot = '0;
    end else if ((rpm_quo - 1'b1) > LAST_SLOT) begin
      slot = LAST_SLOT;
    end else begin
      slot = rpm_quo - 1'b1;
    end
  end

  // Updates read the table as they are accepted; table items write it then.
  // A write and a read never fall on the same edge, so no forwarding is needed.
  assign rd_en   = accept && (command == icdc_pkg::CMD_UPDATE);
  assign rd_addr = ADDR_W'(slot);
  assign wr_en   = accept && (command == icdc_pkg::CMD_TABLE) &&
                   (IDX_CMP_W'(table_index) < IDX_CMP_W'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(table_index);
  assign wr_data = table_value;

  // Stage register: valid control and payload, including the dwell angle product.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (accept) begin
      stage.valid <= 1'b1;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
    if (accept) begin
      stage.is_write  <= (command == icdc_pkg::CMD_TABLE);
      stage.rolled    <= cycle_wrap;
      stage.angle     <= angle;
      stage.rpm       <= rpm;
      stage.timestamp <= timestamp_us;
      stage.need      <= icdc_pkg::NEED_W'(deg_per_us) * icdc_pkg::NEED_W'(min_dwell_us);
    end
  end

endmodule

`default_nettype wire

>>> design/icdc_seq.sv
// Coil sequencer: decides discharge, charge or re-prime for each update and
// holds the result register. Depends on icdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icdc_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire icdc_pkg::icdc_stage_t         stage,
  input  wire logic [icdc_pkg::ANGLE_W-1:0]  table_data,
  input  wire logic [icdc_pkg::DWELL_W-1:0]  max_dwell_us,
  input  wire logic [icdc_pkg::RPM_W-1:0]    min_speed_rpm,
  output logic                               advance,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [icdc_pkg::STATE_W-1:0]  coil_state,
  output logic                               coil_drive,
  output logic      [icdc_pkg::RPM_W-1:0]    charge_start_rpm,
  output logic      [icdc_pkg::ANGLE_W-1:0]  fire_angle
);

  typedef enum logic [2:0] {
    MODE_PRIMED     = 3'b001,
    MODE_CHARGING   = 3'b010,
    MODE_DISCHARGED = 3'b100
  } mode_t;

  mode_t                          mode;
  mode_t                          mode_next;
  logic [icdc_pkg::ANGLE_W-1:0]   target_reg;
  logic [icdc_pkg::ANGLE_W-1:0]   target_reg_next;
  logic [icdc_pkg::TIME_W-1:0]    start_time;
  logic [icdc_pkg::TIME_W-1:0]    start_time_next;
  logic [icdc_pkg::RPM_W-1:0]     start_speed;
  logic [icdc_pkg::RPM_W-1:0]     start_speed_next;

  logic [icdc_pkg::ANGLE_W-1:0]   target;
  logic [icdc_pkg::TIME_W-1:0]    dwell;
  logic [icdc_pkg::NEED_W-1:0]    avail;
  logic                           at_target;
  logic                           discharge;
  logic                           charge;
  logic [icdc_pkg::STATE_W-1:0]   state_code;

  // The stage moves on when the result register is empty or being emptied.
  assign advance = stage.valid && (!out_valid || out_ready);

  // Decision logic for the item in the stage.
  always_comb begin
    target    = (mode == MODE_PRIMED) ? table_data : target_reg;
    dwell     = stage.timestamp - start_time;
    at_target = stage.angle >= target;
    avail     = icdc_pkg::NEED_W'(target - stage.angle) << icdc_pkg::AVAIL_SH;
    discharge = (mode == MODE_CHARGING) &&
                (at_target || (dwell >= icdc_pkg::TIME_W'(max_dwell_us)));
    charge    = !discharge && (mode == MODE_PRIMED) && !at_target &&
                (stage.rpm >= min_speed_rpm) && (avail <= stage.need);

    mode_next        = mode;
    target_reg_next  = target_reg;
    start_time_next  = start_time;
    start_speed_next = start_speed;
    if (!stage.is_write) begin
      target_reg_next = target;
      if (discharge) begin
        mode_next = MODE_DISCHARGED;
      end else if (charge) begin
        mode_next        = MODE_CHARGING;
        start_time_next  = stage.timestamp;
        start_speed_next = stage.rpm;
      end else if ((mode != MODE_CHARGING) && stage.rolled) begin
        mode_next        = MODE_PRIMED;
        start_speed_next = '0;
      end
    end
  end

  // Result code of the next coil state.
  always_comb begin
    case (mode_next)
      MODE_PRIMED:     state_code = icdc_pkg::STATE_PRIMED;
      MODE_CHARGING:   state_code = icdc_pkg::STATE_CHARGING;
      MODE_DISCHARGED: state_code = icdc_pkg::STATE_DISCHARGED;
      default:         state_code = icdc_pkg::STATE_PRIMED;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PRIMED;
      target_reg  <= '0;
      start_time  <= '0;
      start_speed <= '0;
    end else if (advance) begin
      mode        <= mode_next;
      target_reg  <= target_reg_next;
      start_time  <= start_time_next;
      start_speed <= start_speed_next;
    end
  end

  // Result register: valid control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      coil_state       <= state_code;
      coil_drive       <= (mode_next == MODE_CHARGING);
      charge_start_rpm <= start_speed_next;
      fire_angle       <= target_reg_next;
    end
  end

endmodule

`default_nettype wire

>>> design/icdc_checker.sv
// Port-level checker for the ignition coil dwell control block, bound to the
// top level. Depends on icdc_pkg and ignition_coil_dwell_control_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ignition_coil_dwell_control_assert.svh"

module icdc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [icdc_pkg::STATE_W-1:0]   coil_state,
  input wire logic [icdc_pkg::RPM_W-1:0]     charge_start_rpm,
  input wire logic [icdc_pkg::ANGLE_W-1:0]   fire_angle
);

  // A stalled result stays in place.
  `ICDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coil_state) && $stable(fire_angle), "result changed while stalled")

  // Input back-pressure only comes from a stalled result.
  `ICDC_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")

  // Two consecutive charging results belong to one charge.
  `ICDC_ASSERT_NOW(a_charge_hold, (out_valid && out_ready && coil_state == icdc_pkg::STATE_CHARGING) ##1 (out_valid && coil_state == icdc_pkg::STATE_CHARGING), $stable(charge_start_rpm) && $stable(fire_angle), "charge record changed during a charge")

  // A result appears only after an item was accepted into the stage register.
  `ICDC_ASSERT_NOW(a_out_source, $rose(out_valid), $past(in_valid && in_ready, 2), "result without an accepted item")

endmodule

bind ignition_coil_dwell_control icdc_checker u_icdc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .coil_state       (coil_state),
  .charge_start_rpm (charge_start_rpm),
  .fire_angle       (fire_angle)
);

`default_nettype wire

>>> sim/tb_ignition_coil_dwell_control.sv
// Self-checking testbench for the ignition coil dwell control block.
// Holds its own model of the coil sequencer and advance table and checks each
// result item against it. Depends on icdc_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_ignition_coil_dwell_control;
  import icdc_pkg::*;

  localparam int SLOTS       = TABLE_DEPTH_DEF;
  localparam int ANGLE_MAX   = 46079;
  localparam int RPM_MAX     = 20000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRV_SIDE    = 0;
  localparam int MON_SIDE    = 1;

  // One input item and one result item as the testbench sees them.
  typedef struct {
    logic               cmd;
    logic               rolled;
    logic [ANGLE_W-1:0] ang;
    logic [DPU_W-1:0]   dpu;
    logic [RPM_W-1:0]   rpm;
    logic [TIME_W-1:0]  ts;
    logic [TIDX_W-1:0]  tidx;
    logic [ANGLE_W-1:0] tval;
  } engine_item_t;

  typedef struct {
    logic [STATE_W-1:0] state;
    logic               drive;
    logic [RPM_W-1:0]   start_rpm;
    logic [ANGLE_W-1:0] target;
  } coil_result_t;

  // Block ports; the inputs are known from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MIN_DWELL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  command = CMD_UPDATE;
  logic                  cycle_wrap = 1'b0;
  logic [ANGLE_W-1:0]    angle = '0;
  logic [DPU_W-1:0]      deg_per_us = '0;
  logic [RPM_W-1:0]      rpm = '0;
  logic [TIME_W-1:0]     timestamp_us = '0;
  logic [TIDX_W-1:0]     table_index = '0;
  logic [ANGLE_W-1:0]    table_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATE_W-1:0]    coil_state;
  logic                  coil_drive;
  logic [RPM_W-1:0]      charge_start_rpm;
  logic [ANGLE_W-1:0]    fire_angle;

  // Shadow configuration and predicted coil state.
  logic [DWELL_W-1:0]    min_dwell_cfg = MIN_DWELL_RST;
  logic [DWELL_W-1:0]    max_dwell_cfg = MAX_DWELL_RST;
  logic [RPM_W-1:0]      min_speed_cfg = MIN_SPEED_RST;
  logic [STATE_W-1:0]    coil_mode = STATE_PRIMED;
  logic [ANGLE_W-1:0]    tgt_angle = '0;
  logic [TIME_W-1:0]     start_time = '0;
  logic [RPM_W-1:0]      start_speed = '0;
  logic [ANGLE_W-1:0]    adv_table [SLOTS];

  // Stimulus bookkeeping.
  engine_item_t          pending_items [$];
  coil_result_t          expected_results [$];
  bit                    slot_loaded [SLOTS];
  int                    n_queued = 0;
  int                    n_sent = 0;
  int                    n_fail = 0;
  int                    calm_left [2] = '{0, 0};
  int                    gap_left = 0;
  int                    stall_left = 0;
  int unsigned           cycle_count = 0;
  engine_item_t          cur_item;
  coil_result_t          want;
  logic                  launch;
  logic                  slot_free;

  ignition_coil_dwell_control dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .cycle_wrap(cycle_wrap),
    .angle(angle), .deg_per_us(deg_per_us), .rpm(rpm), .timestamp_us(timestamp_us),
    .table_index(table_index), .table_value(table_value),
    .out_valid(out_valid), .out_ready(out_ready), .coil_state(coil_state),
    .coil_drive(coil_drive), .charge_start_rpm(charge_start_rpm), .fire_angle(fire_angle)
  );

  // Advance table entry for a given speed, clamped to the table.
  function automatic int rpm_to_slot(logic [RPM_W-1:0] spd);
    int q;
    q = int'(spd) / RPM_STEP;
    if (q == 0) return 0;
    q = q - 1;
    return (q > SLOTS - 1) ? SLOTS - 1 : q;
  endfunction

  // Advances the predicted coil sequencer by one item and returns its result.
  function automatic coil_result_t step_coil(engine_item_t it);
    coil_result_t     r;
    logic [TIME_W-1:0] dwell;
    longint unsigned  avail;
    longint unsigned  need;
    logic             fire;
    logic             charge;
    fire = 1'b0;
    charge = 1'b0;
    if (it.cmd == CMD_TABLE) begin
      if (it.tidx < SLOTS) adv_table[it.tidx] = it.tval;
    end else begin
      if (coil_mode == STATE_PRIMED) tgt_angle = adv_table[rpm_to_slot(it.rpm)];
      if (coil_mode == STATE_CHARGING) begin
        dwell = it.ts - start_time;
        fire = (it.ang >= tgt_angle) || (dwell >= max_dwell_cfg);
      end
      if (!fire && coil_mode == STATE_PRIMED && it.ang < tgt_angle &&
          it.rpm >= min_speed_cfg) begin
        avail = 64'(tgt_angle - it.ang) << DPU_FRAC_BITS;
        need = (64'(it.dpu) * 64'(min_dwell_cfg)) << ANGLE_FRAC_BITS;
        charge = (avail <= need);
      end
      if (fire) begin
        coil_mode = STATE_DISCHARGED;
      end else if (charge) begin
        coil_mode = STATE_CHARGING;
        start_time = it.ts;
        start_speed = it.rpm;
      end else if (coil_mode != STATE_CHARGING && it.rolled) begin
        coil_mode = STATE_PRIMED;
        start_speed = '0;
      end
    end
    r.state = coil_mode;
    r.drive = (coil_mode == STATE_CHARGING);
    r.start_rpm = start_speed;
    r.target = tgt_angle;
    return r;
  endfunction

  // Wait before the next item or result; now and then a calm stretch with none.
  function automatic int draw_wait(int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic push_table(logic [TIDX_W-1:0] idx, logic [ANGLE_W-1:0] val);
    engine_item_t it;
    it.cmd = CMD_TABLE;
    it.rolled = 1'($urandom);
    it.ang = ANGLE_W'($urandom_range(0, ANGLE_MAX));
    it.dpu = DPU_W'($urandom);
    it.rpm = RPM_W'($urandom_range(0, RPM_MAX));
    it.ts = $urandom;
    it.tidx = idx;
    it.tval = val;
    if (idx < SLOTS) slot_loaded[idx] = 1'b1;
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Queues an engine update, loading its table entry first if it was never written.
  task automatic push_update(logic rl, logic [ANGLE_W-1:0] ang, logic [DPU_W-1:0] dpu,
                             logic [RPM_W-1:0] spd, logic [TIME_W-1:0] ts);
    engine_item_t it;
    int           s;
    s = rpm_to_slot(spd);
    if (!slot_loaded[s]) push_table(TIDX_W'(s), ANGLE_W'($urandom_range(0, ANGLE_MAX)));
    it.cmd = CMD_UPDATE;
    it.rolled = rl;
    it.ang = ang;
    it.dpu = dpu;
    it.rpm = spd;
    it.ts = ts;
    it.tidx = TIDX_W'($urandom);
    it.tval = ANGLE_W'($urandom);
    pending_items.push_back(it);
    n_queued++;
  endtask

  // One engine revolution or so: rising angle and time at a steady-ish speed.
  task automatic push_engine_cycle();
    logic [RPM_W-1:0]  spd;
    logic [DPU_W-1:0]  dpu;
    logic [TIME_W-1:0] ts;
    logic              wrap;
    int                ang;
    int                steps;
    int                lo;
    int                hi;
    spd = RPM_W'($urandom_range(0, RPM_MAX));
    dpu = DPU_W'($urandom) >> $urandom_range(0, 20);
    ang = $urandom_range(0, 4000);
    steps = $urandom_range(4, 20);
    ts = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095) : $urandom;
    wrap = 1'b1;
    for (int k = 0; k < steps; k++) begin
      push_update(wrap, ANGLE_W'(ang), dpu, spd, ts);
      wrap = 1'b0;
      ang = ang + $urandom_range(0, 6000);
      if (ang > ANGLE_MAX) begin
        ang = ang - (ANGLE_MAX + 1);
        wrap = 1'b1;
      end
      ts = ts + $urandom_range(0, 2500);
      if ($urandom_range(0, 3) == 0) begin
        lo = (spd > 50) ? int'(spd) - 50 : 0;
        hi = (spd < RPM_MAX - 50) ? int'(spd) + 50 : RPM_MAX;
        spd = RPM_W'($urandom_range(lo, hi));
      end
    end
  endtask

  // Mostly well-formed engine cycles, with table writes and noise updates mixed in.
  task automatic fill_random(int goal);
    int start;
    start = n_queued;
    while (n_queued - start < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_engine_cycle();
        6: push_table(($urandom_range(0, 9) == 0) ? TIDX_W'($urandom_range(SLOTS, 63)) :
                      TIDX_W'($urandom_range(0, SLOTS - 1)),
                      ANGLE_W'($urandom_range(0, ANGLE_MAX)));
        default: repeat ($urandom_range(1, 4))
          push_update(1'($urandom), ANGLE_W'($urandom_range(0, ANGLE_MAX)), DPU_W'($urandom),
                      RPM_W'($urandom_range(0, RPM_MAX)), $urandom);
      endcase
    end
  endtask

  // Waits until every queued item has gone in and every result has come back.
  task automatic wait_drained();
    while (n_sent != n_queued || expected_results.size() != 0) @(posedge clk);
  endtask

  // One register write; valid is already high.
  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_DWELL: min_dwell_cfg = val;
      CFG_MAX_DWELL: max_dwell_cfg = val;
      CFG_MIN_SPEED: min_speed_cfg = RPM_W'(val);
      default: ;
    endcase
  endtask

  task automatic write_config(logic [DWELL_W-1:0] md, logic [DWELL_W-1:0] xd,
                              logic [RPM_W-1:0] ms);
    @(posedge clk);
    cfg_valid <= 1'b1;
    put_reg(CFG_MIN_DWELL, md);
    put_reg(CFG_MAX_DWELL, xd);
    put_reg(CFG_MIN_SPEED, CFG_DATA_W'(ms));
    cfg_valid <= 1'b0;
  endtask

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  // Run sequence: directed items at reset settings, then random phases.
  initial begin
    logic [TIME_W-1:0] t0;
    t0 = 32'hFFFF_F800;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Table loads, including writes past the end that must be ignored.
    push_table(0, ANGLE_MAX);
    push_table(SLOTS - 1, 0);
    push_table(63, 16'h1234);
    push_table(SLOTS, ANGLE_MAX);
    push_table(1, 500);
    push_table(2, 500);
    push_table(19, 3200);
    // Zero speed and full speed: both ends of the table lookup.
    push_update(1'b0, 0, 24'hFFFFFF, 0, 0);
    push_update(1'b1, 0, 24'hFFFFFF, RPM_MAX, 32'hFFFF_FFFF);
    // One step short of the charge threshold, then exactly on it.
    push_update(1'b0, 3075, 16383, 2000, t0 - 16);
    push_update(1'b0, 3075, 16384, 2000, t0);
    // A table write while charging leaves the coil alone.
    push_table(5, 100);
    // Rollover is ignored while charging; dwell runs across the timer wrap.
    push_update(1'b1, 3100, 0, 2050, t0 + 100);
    push_update(1'b0, 3150, 0, 2050, t0 + 3999);
    push_update(1'b0, 3160, 0, 2050, t0 + 4000);
    // Discharged holds its target until a rollover re-primes it.
    push_update(1'b0, 3170, 24'hFFFFFF, 600, t0 + 4100);
    push_update(1'b1, 10, 0, 2050, t0 + 5000);
    push_update(1'b0, 3199, 0, 2050, t0 + 5100);
    // Speed just under and at the minimum, then the angle reaching the target.
    push_update(1'b0, 499, 24'hFFFFFF, 299, t0 + 6000);
    push_update(1'b0, 499, 24'hFFFFFF, 300, t0 + 6100);
    push_update(1'b0, 500, 24'hFFFFFF, 300, t0 + 6200);
    push_update(1'b1, ANGLE_MAX, 24'hFFFFFF, 199, t0 + 6300);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_config(0, 0, 0);
        1: write_config(16'hFFFF, 16'hFFFF, RPM_W'(RPM_MAX));
        2, 3: write_config(DWELL_W'($urandom_range(500, 5000)),
                           DWELL_W'($urandom_range(1000, 10000)),
                           RPM_W'($urandom_range(0, 2000)));
        4: write_config(DWELL_W'($urandom), DWELL_W'($urandom),
                        RPM_W'($urandom_range(0, RPM_MAX)));
        default: write_config(MIN_DWELL_RST, MAX_DWELL_RST, MIN_SPEED_RST);
      endcase
      fill_random(305);
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("ignition_coil_dwell_control: match");
    end else begin
      $display("ignition_coil_dwell_control: mismatch");
    end
    $finish;
  end

  // Driver: presents queued items, predicting each result as its item is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      launch = 1'b0;
      if (in_valid && in_ready) begin
        expected_results.push_back(step_coil(cur_item));
        n_sent++;
        gap_left = draw_wait(DRV_SIDE);
      end
      slot_free = !in_valid || in_ready;
      if (slot_free) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          launch = 1'b1;
        end
      end
      in_valid <= slot_free ? launch : 1'b1;
      if (launch) begin
        command <= cur_item.cmd;
        cycle_wrap <= cur_item.rolled;
        angle <= cur_item.ang;
        deg_per_us <= cur_item.dpu;
        rpm <= cur_item.rpm;
        timestamp_us <= cur_item.ts;
        table_index <= cur_item.tidx;
        table_value <= cur_item.tval;
      end
    end
  end

  // Monitor: takes result items with random stalls and checks every field.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no item outstanding");
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (coil_state !== want.state) begin
            $error("coil_state: expected %0d, got %0d", want.state, coil_state);
            n_fail++;
          end
          if (coil_drive !== want.drive) begin
            $error("coil_drive: expected %0d, got %0d", want.drive, coil_drive);
            n_fail++;
          end
          if (charge_start_rpm !== want.start_rpm) begin
            $error("charge_start_rpm: expected %0d, got %0d", want.start_rpm,
                   charge_start_rpm);
            n_fail++;
          end
          if (fire_angle !== want.target) begin
            $error("fire_angle: expected %0d, got %0d", want.target, fire_angle);
            n_fail++;
          end
        end
        stall_left = draw_wait(MON_SIDE);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ignition_coil_dwell_control: mismatch");
      $finish;
    end
  end

endmodule

>>> sim.f
+incdir+design
design/icdc_pkg.sv
design/icdc_table.sv
design/icdc_front.sv
design/icdc_seq.sv
design/ignition_coil_dwell_control.sv
design/icdc_checker.sv
sim/tb_ignition_coil_dwell_control.sv
